[hdl/mqlb_pkg.sv]
package mqlb_pkg;

    // Default sizes of the shared buffer.
    localparam int SLOTS_DEF      = 16;
    localparam int QUEUES_DEF     = 4;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths on the stream ports.
    localparam int PUSH_DATA_W = 32;
    localparam int POP_DATA_W  = 32;
    localparam int QNUM_W      = 2;
    localparam int IN_USER_W   = 1 + QNUM_W;
    localparam int STATUS_W    = 2;

    typedef enum logic {
        REQ_PUSH = 1'b0,
        REQ_POP  = 1'b1
    } t_req;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

endpackage

[hdl/mqlb_ram.sv]
module mqlb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/mqlb_fwd_ram.sv]
module mqlb_fwd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] ram_rdata;
    logic             r_hit;
    logic [WIDTH-1:0] r_fwd;

    mqlb_ram #(
        .WIDTH (WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_we),
        .i_waddr (i_waddr),
        .i_wdata (i_wdata),
        .i_re    (i_re),
        .i_raddr (i_raddr),
        .o_rdata (ram_rdata)
    );

    // A read that collides with a write in the same cycle returns the new word.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_hit <= i_we && (i_waddr == i_raddr);
            r_fwd <= i_wdata;
        end
    end

    assign o_rdata = r_hit ? r_fwd : ram_rdata;

endmodule

[hdl/multi_queue_linked_buffer_core.sv]
// A transaction accepted into the request register moves to the output register once the
// output register is free or being emptied. Throughput: one request per cycle while that holds;
// the next request's link and data reads are issued at its accept edge with the state the
// request ahead of it leaves behind.
// Reset (synchronous, active low) empties all queues and puts every slot on the free
// list; the buffer memories themselves are not cleared.
module multi_queue_linked_buffer_core #(
    parameter int SLOTS      = mqlb_pkg::SLOTS_DEF,
    parameter int QUEUES     = mqlb_pkg::QUEUES_DEF,
    parameter int DATA_WIDTH = mqlb_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // push_data
    input  logic [mqlb_pkg::PUSH_DATA_W-1:0] i_s_axis_tdata,
    // req_type, queue_number
    input  logic [mqlb_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pop_data
    output logic [mqlb_pkg::POP_DATA_W-1:0]  o_m_axis_tdata,
    // status
    output logic [mqlb_pkg::STATUS_W-1:0]    o_m_axis_tuser
);

    import mqlb_pkg::*;

    localparam int AW  = $clog2(SLOTS);
    localparam int PW  = $clog2(SLOTS + 1);
    localparam int QIW = (QUEUES > 1) ? $clog2(QUEUES) : 1;

    // Queue table: a queue's head and tail are meaningful only while it is not empty.
    logic [AW-1:0]     r_head [QUEUES];
    logic [AW-1:0]     r_tail [QUEUES];
    logic [QUEUES-1:0] r_nonempty;
    logic [AW-1:0]     n_head [QUEUES];
    logic [AW-1:0]     n_tail [QUEUES];
    logic [QUEUES-1:0] n_nonempty;

    // Free list head (SLOTS means no free slot) and the count of slots ever handed out.
    // Slots at and above the count were never used and chain in index order.
    logic [PW-1:0] r_free_head;
    logic [PW-1:0] r_fresh;
    logic [PW-1:0] n_free_head;
    logic [PW-1:0] n_fresh;

    // Request being executed.
    logic                   r_b_valid;
    t_req                   r_b_req;
    logic                   r_b_qok;
    logic [QIW-1:0]         r_b_qi;
    logic [PUSH_DATA_W-1:0] r_b_data;

    // Result register.
    logic                  r_out_valid;
    logic [POP_DATA_W-1:0] r_pop_data;
    t_status               r_status;

    logic                  b_go;
    logic                  s_accept;
    logic [QNUM_W-1:0]     in_q;
    logic                  in_qok;
    logic [QIW-1:0]        in_qi;
    logic [QIW-1:0]        in_qi_safe;
    logic [AW-1:0]         b_slot;
    logic [AW-1:0]         b_head;
    logic [AW-1:0]         b_tail;
    logic                  b_nonempty;

    logic                  link_we;
    logic [AW-1:0]         link_wa;
    logic [PW-1:0]         link_wd;
    logic [AW-1:0]         link_ra;
    logic [PW-1:0]         link_rd;
    logic                  data_we;
    logic [DATA_WIDTH-1:0] data_wd;
    logic [AW-1:0]         data_ra;
    logic [DATA_WIDTH-1:0] data_rd;
    logic [POP_DATA_W-1:0] pop_word;

    logic [POP_DATA_W-1:0] res_data;
    t_status               res_status;

    assign b_go            = r_b_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_b_valid || b_go;
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;

    assign in_q       = i_s_axis_tuser[QNUM_W:1];
    assign in_qok     = 32'(in_q) < QUEUES;
    assign in_qi      = QIW'(in_q);
    assign in_qi_safe = in_qok ? in_qi : '0;

    assign b_slot     = r_free_head[AW-1:0];
    assign b_head     = r_head[r_b_qi];
    assign b_tail     = r_tail[r_b_qi];
    assign b_nonempty = r_b_qok && r_nonempty[r_b_qi];

    generate
        if (DATA_WIDTH >= POP_DATA_W) begin : g_wide
            assign pop_word = data_rd[POP_DATA_W-1:0];
        end else begin : g_narrow
            assign pop_word = {{(POP_DATA_W - DATA_WIDTH){data_rd[DATA_WIDTH-1]}}, data_rd};
        end
        if (DATA_WIDTH >= PUSH_DATA_W) begin : g_wr_wide
            assign data_wd = DATA_WIDTH'(r_b_data);
        end else begin : g_wr_narrow
            assign data_wd = r_b_data[DATA_WIDTH-1:0];
        end
    endgenerate

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_nonempty  = r_nonempty;
        n_free_head = r_free_head;
        n_fresh     = r_fresh;
        link_we     = 1'b0;
        link_wa     = '0;
        link_wd     = '0;
        data_we     = 1'b0;
        res_data    = '0;
        res_status  = ST_OK;
        if (b_go) begin
            if (r_b_req == REQ_PUSH) begin
                if (!r_b_qok || (r_free_head == PW'(SLOTS))) begin
                    res_status = ST_FULL;
                end else begin
                    data_we = 1'b1;
                    if (b_nonempty) begin
                        link_we = 1'b1;
                        link_wa = b_tail;
                        link_wd = PW'(b_slot);
                    end else begin
                        n_head[r_b_qi] = b_slot;
                    end
                    n_tail[r_b_qi]     = b_slot;
                    n_nonempty[r_b_qi] = 1'b1;
                    if (r_free_head == r_fresh) begin
                        n_fresh     = r_fresh + PW'(1);
                        n_free_head = r_fresh + PW'(1);
                    end else begin
                        n_free_head = link_rd;
                    end
                end
            end else begin
                if (!b_nonempty) begin
                    res_data   = '1;
                    res_status = ST_EMPTY;
                end else begin
                    res_data = pop_word;
                    if (b_head == b_tail) begin
                        n_nonempty[r_b_qi] = 1'b0;
                    end else begin
                        n_head[r_b_qi] = link_rd[AW-1:0];
                    end
                    link_we     = 1'b1;
                    link_wa     = b_head;
                    link_wd     = r_free_head;
                    n_free_head = PW'(b_head);
                end
            end
        end
    end

    // Reads for the incoming request use the state left by the request executing now.
    assign data_ra = n_head[in_qi_safe];
    assign link_ra = (i_s_axis_tuser[0] == REQ_POP) ? n_head[in_qi_safe]
                                                    : n_free_head[AW-1:0];

    mqlb_fwd_ram #(
        .WIDTH (PW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_wa),
        .i_wdata (link_wd),
        .i_re    (s_accept),
        .i_raddr (link_ra),
        .o_rdata (link_rd)
    );

    mqlb_fwd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (b_slot),
        .i_wdata (data_wd),
        .i_re    (s_accept),
        .i_raddr (data_ra),
        .o_rdata (data_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_nonempty  <= '0;
            r_free_head <= '0;
            r_fresh     <= '0;
        end else begin
            if (s_accept) begin
                r_b_valid <= 1'b1;
            end else if (b_go) begin
                r_b_valid <= 1'b0;
            end
            if (b_go) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            r_nonempty  <= n_nonempty;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        r_tail <= n_tail;
        if (s_accept) begin
            r_b_req  <= t_req'(i_s_axis_tuser[0]);
            r_b_qok  <= in_qok;
            r_b_qi   <= in_qi_safe;
            r_b_data <= i_s_axis_tdata;
        end
        if (b_go) begin
            r_pop_data <= res_data;
            r_status   <= res_status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_pop_data;
    assign o_m_axis_tuser  = r_status;

endmodule

[tb/multi_queue_linked_buffer_checker.sv]
module multi_queue_linked_buffer_checker #(
    parameter int SLOTS      = mqlb_pkg::SLOTS_DEF,
    parameter int QUEUES     = mqlb_pkg::QUEUES_DEF,
    parameter int DATA_WIDTH = mqlb_pkg::DATA_WIDTH_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    // push_data
    input  logic [mqlb_pkg::PUSH_DATA_W-1:0] i_s_axis_tdata,
    // req_type, queue_number
    input  logic [mqlb_pkg::IN_USER_W-1:0]   i_s_axis_tuser,
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // pop_data
    input  logic [mqlb_pkg::POP_DATA_W-1:0]  i_m_axis_tdata,
    // status
    input  logic [mqlb_pkg::STATUS_W-1:0]    i_m_axis_tuser,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_pushes_stored,
    output int                               o_pushes_refused,
    output int                               o_pops_served,
    output int                               o_pops_empty
);

    import mqlb_pkg::*;

    localparam int LINK_W = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(SLOTS);

    typedef struct packed {
        logic [POP_DATA_W-1:0] pop_data;
        t_status               status;
    } reply_t;

    reply_t expected_replies[$];

    // Shadow copy of the buffer: words, links, queue ends and the free list.
    logic signed [DATA_WIDTH-1:0] slot_word [SLOTS];
    logic [LINK_W-1:0]            slot_next [SLOTS];
    logic [LINK_W-1:0]            head_of   [QUEUES];
    logic [LINK_W-1:0]            tail_of   [QUEUES];
    logic [LINK_W-1:0]            free_slot;

    function automatic reply_t serve_request(input t_req req, input int unsigned qn,
                                             input logic [PUSH_DATA_W-1:0] word);
        reply_t            rep;
        logic [LINK_W-1:0] slot;
        rep.pop_data = '0;
        rep.status   = ST_OK;
        if (req == REQ_PUSH) begin
            if (qn >= QUEUES || free_slot == LINK_NULL) begin
                rep.status = ST_FULL;
            end else begin
                slot      = free_slot;
                free_slot = slot_next[slot];
                if (head_of[qn] == LINK_NULL) begin
                    head_of[qn] = slot;
                end else begin
                    slot_next[tail_of[qn]] = slot;
                end
                slot_next[slot] = LINK_NULL;
                tail_of[qn]     = slot;
                slot_word[slot] = DATA_WIDTH'(word);
            end
        end else begin
            if (qn >= QUEUES || head_of[qn] == LINK_NULL) begin
                rep.pop_data = '1;
                rep.status   = ST_EMPTY;
            end else begin
                slot        = head_of[qn];
                head_of[qn] = slot_next[slot];
                if (head_of[qn] == LINK_NULL) begin
                    tail_of[qn] = LINK_NULL;
                end
                slot_next[slot] = free_slot;
                free_slot       = slot;
                // The stored word is signed, so the size cast sign-extends it.
                rep.pop_data = POP_DATA_W'(slot_word[slot]);
            end
        end
        return rep;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (o_fail_count < 200) begin
            $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $time);
        end
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        reply_t want;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_next[i] = LINK_W'(i + 1);
            end
            slot_next[SLOTS-1] = LINK_NULL;
            for (int i = 0; i < QUEUES; i++) begin
                head_of[i] = LINK_NULL;
                tail_of[i] = LINK_NULL;
            end
            free_slot = '0;
            expected_replies.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                want = serve_request(t_req'(i_s_axis_tuser[0]), int'(i_s_axis_tuser[2:1]),
                                     i_s_axis_tdata);
                expected_replies.push_back(want);
                case (want.status)
                    ST_FULL:  o_pushes_refused++;
                    ST_EMPTY: o_pops_empty++;
                    default: begin
                        if (i_s_axis_tuser[0] == REQ_PUSH) begin
                            o_pushes_stored++;
                        end else begin
                            o_pops_served++;
                        end
                    end
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_replies.size() == 0) begin
                    report_mismatch("result with no request waiting", i_m_axis_tdata, '0);
                end else begin
                    want = expected_replies.pop_front();
                    if (i_m_axis_tdata !== want.pop_data) begin
                        report_mismatch("pop_data", i_m_axis_tdata, want.pop_data);
                    end
                    if (i_m_axis_tuser !== want.status) begin
                        report_mismatch("status", 32'(i_m_axis_tuser), 32'(want.status));
                    end
                end
            end
        end
        o_pending <= expected_replies.size();
    end

endmodule

[tb/multi_queue_linked_buffer_core_tb.sv]
module multi_queue_linked_buffer_core_tb;

    import mqlb_pkg::*;

    localparam int RANDOM_REQUESTS = 1300;
    localparam int HOLDOFF_CYCLES  = 120;
    localparam int DRAIN_CYCLES    = 10;

    typedef enum int {
        DRAIN_FREE,
        DRAIN_MOSTLY,
        DRAIN_SPARSE,
        DRAIN_COIN
    } drain_mode_t;

    typedef enum int {
        LOAD_FILL,
        LOAD_MIXED,
        LOAD_EMPTY
    } load_mode_t;

    logic                   clk;
    logic                   rst_n        = 1'b0;
    logic                   req_valid    = 1'b0;
    logic                   req_ready;
    logic [PUSH_DATA_W-1:0] req_word     = '0;
    logic [IN_USER_W-1:0]   req_user     = '0;
    logic                   reply_valid;
    logic                   reply_ready  = 1'b0;
    logic [POP_DATA_W-1:0]  reply_word;
    logic [STATUS_W-1:0]    reply_status;

    int fail_count;
    int pending;
    int pushes_stored;
    int pushes_refused;
    int pops_served;
    int pops_empty;

    int burst_left      = 0;
    bit holdoff_request = 1'b0;

    multi_queue_linked_buffer_core dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (req_valid),
        .o_s_axis_tready (req_ready),
        .i_s_axis_tdata  (req_word),
        .i_s_axis_tuser  (req_user),
        .o_m_axis_tvalid (reply_valid),
        .i_m_axis_tready (reply_ready),
        .o_m_axis_tdata  (reply_word),
        .o_m_axis_tuser  (reply_status)
    );

    multi_queue_linked_buffer_checker reply_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_s_axis_tvalid  (req_valid),
        .i_s_axis_tready  (req_ready),
        .i_s_axis_tdata   (req_word),
        .i_s_axis_tuser   (req_user),
        .i_m_axis_tvalid  (reply_valid),
        .i_m_axis_tready  (reply_ready),
        .i_m_axis_tdata   (reply_word),
        .i_m_axis_tuser   (reply_status),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_pushes_stored  (pushes_stored),
        .o_pushes_refused (pushes_refused),
        .o_pops_served    (pops_served),
        .o_pops_empty     (pops_empty)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offers one request and returns at the edge where the transaction completes.
    // Valid stays high between requests of the same burst.
    task automatic send_request(input t_req req, input logic [QNUM_W-1:0] qn,
                                input logic [PUSH_DATA_W-1:0] word);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        req_valid <= 1'b1;
        req_word  <= word;
        req_user  <= {qn, req};
        do begin
            @(posedge clk);
        end while (!(req_valid && req_ready));
        burst_left--;
    endtask

    function automatic logic [PUSH_DATA_W-1:0] pick_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h8000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Receiver: changes its stall pattern every so often, with one long hold-off on request.
    initial begin
        drain_mode_t mode;
        int          mode_left;
        mode      = DRAIN_FREE;
        mode_left = 0;
        forever begin
            @(posedge clk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                reply_ready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge clk);
            end
            if (mode_left == 0) begin
                mode      = drain_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 150);
            end
            mode_left--;
            case (mode)
                DRAIN_FREE:   reply_ready <= 1'b1;
                DRAIN_MOSTLY: reply_ready <= ($urandom_range(0, 3) != 0);
                DRAIN_SPARSE: reply_ready <= ($urandom_range(0, 3) == 0);
                default:      reply_ready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    initial begin
        load_mode_t          load;
        logic [QNUM_W-1:0]   hot_queue;
        logic [QNUM_W-1:0]   qn;
        t_req                req;
        int                  push_pct;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on every empty queue, then extreme words on each queue.
        for (int q = 0; q < QUEUES_DEF; q++) begin
            send_request(REQ_POP, QNUM_W'(q), pick_word());
        end
        send_request(REQ_PUSH, 2'd0, 32'h7FFF_FFFF);
        send_request(REQ_PUSH, 2'd1, 32'h8000_0000);
        send_request(REQ_PUSH, 2'd2, 32'h0000_0000);
        send_request(REQ_PUSH, 2'd3, 32'hFFFF_FFFF);
        // These pops empty their queues, so the tails must go back to null.
        send_request(REQ_POP, 2'd1, 32'h0);
        send_request(REQ_POP, 2'd3, 32'hFFFF_FFFF);
        // Two slots are in use; fourteen more pushes fill the buffer and one is refused.
        for (int i = 0; i < 14; i++) begin
            send_request(REQ_PUSH, QNUM_W'(i), 32'hA5A5_0000 + i);
        end
        send_request(REQ_PUSH, 2'd3, 32'h5A5A_5A5A);

        load      = LOAD_EMPTY;
        hot_queue = '0;
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 60 == 0) begin
                load      = load_mode_t'($urandom_range(0, 2));
                hot_queue = QNUM_W'($urandom_range(0, QUEUES_DEF - 1));
            end
            if (n == 200 || n == 800) begin
                holdoff_request = 1'b1;
            end
            case (load)
                LOAD_FILL:  push_pct = 80;
                LOAD_EMPTY: push_pct = 20;
                default:    push_pct = 50;
            endcase
            req = ($urandom_range(1, 100) <= push_pct) ? REQ_PUSH : REQ_POP;
            qn  = ($urandom_range(0, 3) != 0) ? hot_queue
                                               : QNUM_W'($urandom_range(0, QUEUES_DEF - 1));
            send_request(req, qn, pick_word());
        end
        req_valid <= 1'b0;

        // The count from the checker is registered, so let the last transaction reach it.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests: %0d pushes stored, %0d pushes refused as full,",
                 pushes_stored + pushes_refused + pops_served + pops_empty,
                 pushes_stored, pushes_refused);
        $display("%0d pops served and %0d pops on empty queues, with stalls on both sides.",
                 pops_served, pops_empty);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("Run stopped: results did not arrive in time.");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[filelist.f]
hdl/mqlb_pkg.sv
hdl/mqlb_ram.sv
hdl/mqlb_fwd_ram.sv
hdl/multi_queue_linked_buffer_core.sv
tb/multi_queue_linked_buffer_checker.sv
tb/multi_queue_linked_buffer_core_tb.sv
